// ----- sv/mll_pkg.sv -----
// ----------------------------------------------------------------------------
// mll_pkg
// Shared types and constants for the ladder low-pass filter.
// ----------------------------------------------------------------------------
package mll_pkg;

    localparam int DATA_W  = 24;
    localparam int FRAC_W  = 20;
    localparam int DIV_NW  = 50;   // dividend width
    localparam int DIV_DW  = 30;   // divisor width
    localparam int DIV_QW  = 25;   // quotient bits produced per division
    localparam int MUL_W   = 25;   // shared multiplier operand width

    // 2*pi in Q32
    localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;

    // output tap weights, Q0.16
    localparam logic [14:0] TAP_W0 = 15'd23651;
    localparam logic [14:0] TAP_W1 = 15'd27348;
    localparam logic [14:0] TAP_W2 = 15'd11659;
    localparam logic [14:0] TAP_W3 = 15'd2882;

    // configuration register indexes
    localparam logic REG_CUTOFF = 1'b0;
    localparam logic REG_EMPH   = 1'b1;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_QW-1:0] quot;
    } t_div_rsp;

endpackage

// ----- sv/moog_ladder_lowpass_top.sv -----
// ----------------------------------------------------------------------------
// moog_ladder_lowpass_top
// Four-pole nonlinear ladder low-pass with resonance, Q4.20 samples.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_axis channel, one transaction per sample, and one
//   filtered sample leaves on the m_axis channel for each one taken.
//   Cutoff (hertz) and emphasis are written through the cfg port while idle;
//   keeping to this is up to the user, the block has no check for it. Each
//   sample runs through one shared 25x25 multiplier and one shared 25-bit
//   restoring divider under a sequencer. The two divisions by the sample
//   rate (target cutoff, smoothing step) are reciprocal multiplies on the
//   shared multiplier; the eight tanh ratios (two per stage) run on the
//   divider. The result is loaded into the output register in S_PUSH, and
//   o_s_axis_tready stays low until then, so a new sample is taken only
//   after the last one has left the sequencer. If the output register is
//   still full because the receiver stalls, the sequencer holds at the end
//   of the item until it drains, and only then takes the next sample.
//   Reset (synchronous, active low) clears all filter state, the smoothed
//   cutoff and the output valid, and loads cutoff 1000 Hz, emphasis 0.
// ----------------------------------------------------------------------------
module moog_ladder_lowpass_top #(
    parameter int SAMPLE_RATE = 48000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [23:0] sample_in
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [23:0] sample_out
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [14:0] i_cfg_data
);

    // floor(n / SAMPLE_RATE) for n < 2^38 as (n * RM_M) >> RM_S, exact
    localparam int          RM_L    = $clog2(SAMPLE_RATE);
    localparam int          RM_S    = 38 + RM_L;
    localparam logic [63:0] RM_M64  = ((64'd1 << RM_S) + 64'(SAMPLE_RATE - 1)) /
                                      64'(SAMPLE_RATE);
    localparam logic [24:0] RM_LO   = RM_M64[24:0];
    localparam logic [13:0] RM_HI   = RM_M64[38:25];
    localparam logic [49:0] TG_HALF = 50'(SAMPLE_RATE) << (31 - mll_pkg::FRAC_W);
    localparam logic [49:0] HALF_F   = 50'(1) << (mll_pkg::FRAC_W - 1);
    localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_TG_HI   = 5'd1;
    localparam logic [4:0] S_TG_LO   = 5'd2;
    localparam logic [4:0] S_TG_DIV  = 5'd3;
    localparam logic [4:0] S_SM_DIV  = 5'd4;
    localparam logic [4:0] S_RM0     = 5'd5;
    localparam logic [4:0] S_RM1     = 5'd6;
    localparam logic [4:0] S_RM2     = 5'd7;
    localparam logic [4:0] S_RM3     = 5'd8;
    localparam logic [4:0] S_RM4     = 5'd9;
    localparam logic [4:0] S_RM5     = 5'd10;
    localparam logic [4:0] S_TAP0    = 5'd11;
    localparam logic [4:0] S_TAP1    = 5'd12;
    localparam logic [4:0] S_TAP2    = 5'd13;
    localparam logic [4:0] S_TAP3    = 5'd14;
    localparam logic [4:0] S_TAP4    = 5'd15;
    localparam logic [4:0] S_OUT     = 5'd16;
    localparam logic [4:0] S_FB      = 5'd17;
    localparam logic [4:0] S_FB2     = 5'd18;
    localparam logic [4:0] S_C_SQ    = 5'd19;
    localparam logic [4:0] S_C_DIV   = 5'd20;
    localparam logic [4:0] S_C_WAIT  = 5'd21;
    localparam logic [4:0] S_C_MUL   = 5'd22;
    localparam logic [4:0] S_C_RES   = 5'd23;
    localparam logic [4:0] S_ST_MUL  = 5'd24;
    localparam logic [4:0] S_ST_UPD  = 5'd25;
    localparam logic [4:0] S_PUSH    = 5'd26;

    function automatic logic [24:0] f_mag(input logic signed [25:0] v);
        logic signed [25:0] a;
        a = v[25] ? -v : v;
        return a[24:0];
    endfunction

    function automatic logic signed [23:0] f_sat(input logic signed [39:0] v);
        if (v > 40'(S_MAX)) return S_MAX;
        if (v < -40'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    logic [4:0]         r_state;
    logic [14:0]        r_cutoff;
    logic [10:0]        r_emph;
    logic signed [23:0] r_x;
    logic [23:0]        r_wc;
    logic signed [24:0] r_gap;
    logic signed [23:0] r_stg [4];
    logic signed [23:0] r_d1, r_d2, r_d3;
    logic signed [51:0] r_acc;
    logic signed [23:0] r_out;
    logic signed [23:0] r_cx;
    logic signed [24:0] r_tp, r_ts;
    logic [1:0]         r_idx;
    logic               r_which;
    logic [49:0]        r_prod;
    logic               r_ovalid;
    logic [23:0]        r_odata;
    logic [37:0]        r_num;
    logic [76:0]        r_rm;
    logic               r_rm_sel;   // 0: target cutoff, 1: smoothing step

    logic [mll_pkg::MUL_W-1:0] w_ma, w_mb;
    mll_pkg::t_div_req         w_req;
    mll_pkg::t_div_rsp         w_rsp;

    logic signed [25:0] w_diff;
    logic [24:0]        w_diff_mag;
    logic [26:0]        w_x2;
    logic [27:0]        w_nn;
    logic [29:0]        w_dd;
    logic [24:0]        w_gmag;
    logic               w_tap_neg;
    logic signed [51:0] w_term;
    logic               w_load;
    logic [25:0]        w_rmq;

    assign w_diff     = 26'(r_tp) - 26'(r_ts);
    assign w_diff_mag = f_mag(w_diff);
    assign w_x2       = 27'((r_prod + HALF_F) >> mll_pkg::FRAC_W);
    assign w_nn       = (28'd27 << mll_pkg::FRAC_W) + 28'(w_x2);
    assign w_dd       = (30'd27 << mll_pkg::FRAC_W) + (30'(w_x2) << 3) + 30'(w_x2);
    assign w_gmag     = f_mag(26'(r_gap));
    assign w_rmq      = 26'(r_rm >> RM_S);

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_TG_HI: begin
                w_ma = 25'(r_cutoff);
                w_mb = 25'(mll_pkg::TWO_PI_Q32[34:17]);
            end
            S_TG_LO: begin
                w_ma = 25'(r_cutoff);
                w_mb = 25'(mll_pkg::TWO_PI_Q32[16:0]);
            end
            S_RM0: begin
                w_ma = r_num[24:0];
                w_mb = RM_LO;
            end
            S_RM1: begin
                w_ma = r_num[24:0];
                w_mb = 25'(RM_HI);
            end
            S_RM2: begin
                w_ma = 25'(r_num[37:25]);
                w_mb = RM_LO;
            end
            S_RM3: begin
                w_ma = 25'(r_num[37:25]);
                w_mb = 25'(RM_HI);
            end
            S_TAP0: begin
                w_ma = f_mag(26'(r_stg[3]));
                w_mb = 25'(mll_pkg::TAP_W0);
            end
            S_TAP1: begin
                w_ma = f_mag(26'(r_d1));
                w_mb = 25'(mll_pkg::TAP_W1);
            end
            S_TAP2: begin
                w_ma = f_mag(26'(r_d2));
                w_mb = 25'(mll_pkg::TAP_W2);
            end
            S_TAP3: begin
                w_ma = f_mag(26'(r_d3));
                w_mb = 25'(mll_pkg::TAP_W3);
            end
            S_FB: begin
                w_ma = f_mag(26'(r_out));
                w_mb = 25'(r_emph);
            end
            S_C_SQ: begin
                w_ma = f_mag(26'(r_cx));
                w_mb = f_mag(26'(r_cx));
            end
            S_C_MUL: begin
                w_ma = f_mag(26'(r_cx));
                w_mb = w_rsp.quot;
            end
            S_ST_MUL: begin
                w_ma = w_diff_mag;
                w_mb = 25'(r_wc);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // divider requests
    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = '0;
        w_req.divisor  = '0;
        case (r_state)
            S_C_DIV: begin
                w_req.start    = 1'b1;
                w_req.dividend = (50'(w_nn) << mll_pkg::FRAC_W) + 50'(w_dd >> 1);
                w_req.divisor  = w_dd;
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    mll_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // sign of the operand multiplied in the previous state of the tap chain
    always_comb begin
        case (r_state)
            S_TAP1:  w_tap_neg = r_stg[3][23];
            S_TAP2:  w_tap_neg = r_d1[23];
            S_TAP3:  w_tap_neg = r_d2[23];
            S_TAP4:  w_tap_neg = r_d3[23];
            default: w_tap_neg = 1'b0;
        endcase
    end
    assign w_term = w_tap_neg ? -$signed(52'(r_prod)) : $signed(52'(r_prod));

    assign w_load = (r_state == S_PUSH) && (!r_ovalid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        r_prod <= 50'(w_ma * w_mb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= 15'd1000;
            r_emph   <= 11'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mll_pkg::REG_CUTOFF: r_cutoff <= i_cfg_data;
                mll_pkg::REG_EMPH:   r_emph   <= i_cfg_data[10:0];
                default:             r_emph   <= r_emph;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_odata <= r_out;
        end
    end

    logic [49:0] w_rnd;
    logic [29:0] w_upd;
    logic [51:0] w_amag;
    logic [36:0] w_omag;
    logic [41:0] w_fbm;
    logic [23:0] w_tgt;
    logic [24:0] w_step;
    logic signed [39:0] w_sv;

    always_comb begin
        w_rnd  = (r_prod + HALF_F) >> mll_pkg::FRAC_W;
        w_upd  = w_rnd[29:0];
        w_amag = r_acc[51] ? 52'(-r_acc) : 52'(r_acc);
        w_omag = 37'((w_amag + 52'd32768) >> 16);
        w_fbm  = 42'((r_prod + 50'd128) >> 8);
        w_tgt  = (w_rmq > 26'(S_MAX)) ? 24'(S_MAX) : w_rmq[23:0];
        w_step = (w_rmq == '0 && r_gap != '0) ? 25'd1 : 25'(w_rmq);
        w_sv   = r_acc[51] ? -$signed(40'(w_omag)) : $signed(40'(w_omag));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wc    <= '0;
            r_stg   <= '{default: '0};
            r_d1    <= '0;
            r_d2    <= '0;
            r_d3    <= '0;
            r_idx   <= '0;
            r_which <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_x     <= i_s_axis_tdata;
                        r_state <= S_TG_HI;
                    end
                end
                S_TG_HI: r_state <= S_TG_LO;
                S_TG_LO: begin
                    r_acc   <= 52'(r_prod) << 17;
                    r_state <= S_TG_DIV;
                end
                S_TG_DIV: begin
                    // rounded cutoff*2pi / (rate << 12), pre-shifted by 12
                    r_num    <= 38'((50'(r_acc) + r_prod + TG_HALF) >>
                                    (32 - mll_pkg::FRAC_W));
                    r_rm_sel <= 1'b0;
                    r_state  <= S_RM0;
                end
                S_SM_DIV: begin
                    r_num    <= 38'((50'(w_gmag) << 3) + (50'(w_gmag) << 1));
                    r_rm_sel <= 1'b1;
                    r_state  <= S_RM0;
                end
                S_RM0: r_state <= S_RM1;
                S_RM1: begin
                    r_rm    <= 77'(r_prod);
                    r_state <= S_RM2;
                end
                S_RM2: begin
                    r_rm    <= r_rm + (77'(r_prod) << 25);
                    r_state <= S_RM3;
                end
                S_RM3: begin
                    r_rm    <= r_rm + (77'(r_prod) << 25);
                    r_state <= S_RM4;
                end
                S_RM4: begin
                    r_rm    <= r_rm + (77'(r_prod) << 50);
                    r_state <= S_RM5;
                end
                S_RM5: begin
                    if (!r_rm_sel) begin
                        r_gap   <= $signed({1'b0, w_tgt}) - $signed({1'b0, r_wc});
                        r_state <= S_SM_DIV;
                    end else begin
                        r_wc    <= r_gap[24] ? r_wc - w_step[23:0] : r_wc + w_step[23:0];
                        r_state <= S_TAP0;
                    end
                end
                S_TAP0: r_state <= S_TAP1;
                S_TAP1: begin
                    r_acc   <= w_term;
                    r_state <= S_TAP2;
                end
                S_TAP2: begin
                    r_acc   <= r_acc + w_term;
                    r_state <= S_TAP3;
                end
                S_TAP3: begin
                    r_acc   <= r_acc + w_term;
                    r_state <= S_TAP4;
                end
                S_TAP4: begin
                    r_acc   <= r_acc + w_term;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_out   <= f_sat(w_sv);
                    r_d3    <= r_d2;
                    r_d2    <= r_d1;
                    r_d1    <= r_stg[3];
                    r_state <= S_FB;
                end
                S_FB: r_state <= S_FB2;
                S_FB2: begin
                    r_cx    <= f_sat(40'(r_x) -
                               (r_out[23] ? -$signed(40'(w_fbm)) : $signed(40'(w_fbm))));
                    r_idx   <= '0;
                    r_which <= 1'b0;
                    r_state <= S_C_SQ;
                end
                S_C_SQ:  r_state <= S_C_DIV;
                S_C_DIV: r_state <= S_C_WAIT;
                S_C_WAIT: begin
                    if (w_rsp.done) begin
                        r_state <= S_C_MUL;
                    end
                end
                S_C_MUL: r_state <= S_C_RES;
                S_C_RES: begin
                    // first pass: tanh of the stage input, second: of the stage itself
                    if (!r_which) begin
                        r_tp    <= r_cx[23] ? -$signed(25'(w_rnd)) : $signed(25'(w_rnd));
                        r_cx    <= r_stg[r_idx];
                        r_which <= 1'b1;
                        r_state <= S_C_SQ;
                    end else begin
                        r_ts    <= r_cx[23] ? -$signed(25'(w_rnd)) : $signed(25'(w_rnd));
                        r_state <= S_ST_MUL;
                    end
                end
                S_ST_MUL: r_state <= S_ST_UPD;
                S_ST_UPD: begin
                    r_stg[r_idx] <= f_sat(40'(r_stg[r_idx]) +
                                    (w_diff[25] ? -$signed(40'(w_upd)) : $signed(40'(w_upd))));
                    r_cx    <= f_sat(40'(r_stg[r_idx]) +
                               (w_diff[25] ? -$signed(40'(w_upd)) : $signed(40'(w_upd))));
                    r_which <= 1'b0;
                    if (r_idx == 2'd3) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_C_SQ;
                    end
                end
                S_PUSH: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

endmodule

// ----- sv/mll_div.sv -----
// ----------------------------------------------------------------------------
// mll_div
// Restoring divider, one quotient bit per cycle. The upper dividend bits
// must be below the divisor so the quotient fits in DIV_QW bits.
// ----------------------------------------------------------------------------
module mll_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mll_pkg::t_div_req i_req,
    output mll_pkg::t_div_rsp o_rsp
);

    logic [mll_pkg::DIV_DW-1:0] r_rem;
    logic [mll_pkg::DIV_QW-1:0] r_q;
    logic [mll_pkg::DIV_DW-1:0] r_div;
    logic [4:0]                 r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [mll_pkg::DIV_DW:0]   w_trial;
    logic                       w_ge;

    assign w_trial = {r_rem, r_q[mll_pkg::DIV_QW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(mll_pkg::DIV_QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= mll_pkg::DIV_DW'(i_req.dividend[mll_pkg::DIV_NW-1:mll_pkg::DIV_QW]);
            r_q   <= i_req.dividend[mll_pkg::DIV_QW-1:0];
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= mll_pkg::DIV_DW'(w_trial - {1'b0, r_div});
            end else begin
                r_rem <= w_trial[mll_pkg::DIV_DW-1:0];
            end
            r_q <= {r_q[mll_pkg::DIV_QW-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule
